// ===== sv/clock_mult_shift_calc_assert.svh =====
// Assertion macros for the clock multiplier and shift calculator.
// Used by the port checker; needs i_clk and i_rst_n in the scope of use.
`ifndef CLOCK_MULT_SHIFT_CALC_ASSERT_SVH
`define CLOCK_MULT_SHIFT_CALC_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CMSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clock_mult_shift_calc: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CMSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clock_mult_shift_calc: next-cycle check failed");

`endif

// ===== sv/cmsc_pkg.sv =====
// Shared widths and controller/datapath interface types for the
// clock multiplier and shift calculator. No dependencies.
package cmsc_pkg;

    localparam int FREQ_W  = 32;
    localparam int MULT_W  = 33;
    localparam int SHIFT_W = 6;
    localparam int NUM_W   = 65;
    localparam int CNT_W   = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture an input beat
        logic head_step;   // one step of the headroom search
        logic trial_start; // form the numerator of the current trial
        logic div_step;    // one restoring division step
        logic next_trial;  // move on to the next smaller shift
        logic out_load;    // write the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic src_zero;    // source frequency is zero
        logic head_busy;   // headroom search still running
        logic div_last;    // this is the final division step
        logic fit;         // quotient fits the headroom
        logic last_trial;  // current trial uses a shift of one
    } t_status;

endpackage

// ===== sv/clock_mult_shift_calc.sv =====
// One beat is worked at a time, so a new beat is taken only once the last
// result is loaded; the time per beat is set by the one-bit-per-cycle
// restoring divider shared by all trials. A zero source skips the divider.
// Reset (synchronous, active low) clears the controller and the output valid.
module clock_mult_shift_calc #(
    parameter int MAX_SHIFT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cmsc_pkg::FREQ_W-1:0]   i_source_freq_hz,
    input  logic [cmsc_pkg::FREQ_W-1:0]   i_target_freq_hz,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cmsc_pkg::MULT_W-1:0]   o_multiplier,
    output logic [cmsc_pkg::SHIFT_W-1:0]  o_shift_amount,
    output logic                          o_divide_error
);
    import cmsc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller state machine.
    cmsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Headroom search, divider and result register.
    cmsc_dp #(
        .MAX_SHIFT (MAX_SHIFT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_source_freq_hz (i_source_freq_hz),
        .i_target_freq_hz (i_target_freq_hz),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_multiplier     (o_multiplier),
        .o_shift_amount   (o_shift_amount),
        .o_divide_error   (o_divide_error)
    );

endmodule

// ===== sv/cmsc_ctrl.sv =====
// Controller state machine of the clock multiplier and shift calculator.
// Depends on cmsc_pkg for the command and status types.
module cmsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  cmsc_pkg::t_status i_status,
    output cmsc_pkg::t_cmd    o_cmd
);
    import cmsc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HEAD   = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // The result register is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (i_status.src_zero) begin
                    n_state = ST_FINISH;
                end else if (i_status.head_busy) begin
                    o_cmd.head_step = 1'b1;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.trial_start = 1'b1;
                n_state           = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.fit || i_status.last_trial) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.next_trial = 1'b1;
                    n_state          = ST_START;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set on a load, cleared when the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/cmsc_dp.sv =====
// Datapath of the clock multiplier and shift calculator: headroom search,
// bit-serial restoring divider and result register. Depends on cmsc_pkg.
module cmsc_dp #(
    parameter int MAX_SHIFT = 32
) (
    input  logic                           i_clk,
    input  logic [cmsc_pkg::FREQ_W-1:0]    i_source_freq_hz,
    input  logic [cmsc_pkg::FREQ_W-1:0]    i_target_freq_hz,
    input  cmsc_pkg::t_cmd                 i_cmd,
    output cmsc_pkg::t_status              o_status,
    output logic [cmsc_pkg::MULT_W-1:0]    o_multiplier,
    output logic [cmsc_pkg::SHIFT_W-1:0]   o_shift_amount,
    output logic                           o_divide_error
);
    import cmsc_pkg::*;

    // The numerator's top bit for shift s sits at bit NUM_W-1 once the
    // rounding term is aligned by 32 - s.
    localparam int ALIGN0 = FREQ_W - MAX_SHIFT;

    logic [FREQ_W-1:0]  r_src, r_tgt, r_span;
    logic               r_err;
    logic [SHIFT_W-1:0] r_head, r_sh;
    logic [NUM_W-1:0]   r_addend, r_num;
    logic [FREQ_W-1:0]  r_rem;
    logic [MULT_W-1:0]  r_quo;
    logic               r_sticky;
    logic [CNT_W-1:0]   r_cnt;
    logic [MULT_W-1:0]  r_mult;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_derr;

    logic [FREQ_W:0]    cand, diff;
    logic               qbit;
    logic               fit;

    // One restoring division step on the next numerator bit. The partial
    // remainder is below the source, so a borrow shows in the top bit.
    assign cand = {r_rem, r_num[NUM_W-1]};
    assign diff = cand - {1'b0, r_src};
    assign qbit = !diff[FREQ_W];

    // The quotient fits when nothing stands at or above bit r_head.
    assign fit = !r_sticky && ((r_quo >> r_head) == '0);

    assign o_status.src_zero   = (r_src == '0);
    assign o_status.head_busy  = (r_span != '0) && (r_head != '0);
    assign o_status.div_last   = (r_cnt == CNT_W'(1));
    assign o_status.fit        = fit;
    assign o_status.last_trial = (r_sh == SHIFT_W'(1));

    // Operand capture and headroom search. Span is source minus one, and
    // each step drops one bit of it while the headroom counts down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src    <= i_source_freq_hz;
            r_tgt    <= i_target_freq_hz;
            r_err    <= (i_source_freq_hz == '0);
            r_span   <= i_source_freq_hz - FREQ_W'(1);
            r_head   <= SHIFT_W'(FREQ_W);
            r_sh     <= SHIFT_W'(MAX_SHIFT);
            r_addend <= NUM_W'(i_source_freq_hz[FREQ_W-1:1]) << ALIGN0;
        end else begin
            if (i_cmd.head_step) begin
                r_span <= r_span >> 1;
                r_head <= r_head - SHIFT_W'(1);
            end
            if (i_cmd.next_trial) begin
                r_sh     <= r_sh - SHIFT_W'(1);
                r_addend <= r_addend << 1;
            end
        end
    end

    // Divider: a trial runs sh + 33 steps, one quotient bit per cycle.
    // Bits that leave the 33-bit quotient register set the sticky flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.trial_start) begin
            r_num    <= {1'b0, r_tgt, {FREQ_W{1'b0}}} + r_addend;
            r_rem    <= '0;
            r_quo    <= '0;
            r_sticky <= 1'b0;
            r_cnt    <= CNT_W'(r_sh) + CNT_W'(MULT_W);
        end else if (i_cmd.div_step) begin
            r_num    <= r_num << 1;
            r_rem    <= qbit ? diff[FREQ_W-1:0] : cand[FREQ_W-1:0];
            r_quo    <= {r_quo[MULT_W-2:0], qbit};
            r_sticky <= r_sticky | r_quo[MULT_W-1];
            r_cnt    <= r_cnt - CNT_W'(1);
        end
    end

    // Result register. A final trial that does not fit reports shift zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mult  <= r_err ? '0 : r_quo;
            r_shift <= (r_err || !fit) ? '0 : r_sh;
            r_derr  <= r_err;
        end
    end

    assign o_multiplier   = r_mult;
    assign o_shift_amount = r_shift;
    assign o_divide_error = r_derr;

endmodule

// ===== sv/cmsc_check.sv =====
// Port checker for the clock multiplier and shift calculator, bound to
// the top level. Depends on cmsc_pkg and clock_mult_shift_calc_assert.svh.
`include "clock_mult_shift_calc_assert.svh"

module cmsc_check #(
    parameter int MAX_SHIFT = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [cmsc_pkg::MULT_W-1:0]   o_multiplier,
    input logic [cmsc_pkg::SHIFT_W-1:0]  o_shift_amount,
    input logic                          o_divide_error
);
    import cmsc_pkg::*;

    logic                        res_zero;
    logic [MULT_W+SHIFT_W:0]     out_beat;

    // Both result fields zero, and the whole result beat as one vector.
    assign res_zero = (o_multiplier == '0) && (o_shift_amount == '0);
    assign out_beat = {o_multiplier, o_shift_amount, o_divide_error};

    // An error beat carries zeros in both result fields.
    `CMSC_ASSERT_NOW(a_err_zero, o_valid && o_divide_error, res_zero)

    // The shift never exceeds the largest trial shift.
    `CMSC_ASSERT_NOW(a_shift_max, o_valid, o_shift_amount <= SHIFT_W'(MAX_SHIFT))

    // A fitted quotient is below two to the headroom, so its top bit is clear.
    `CMSC_ASSERT_NOW(a_fit_top, o_valid && (o_shift_amount != '0), !o_multiplier[MULT_W-1])

    // An accepted input beat makes the block busy in the next cycle.
    `CMSC_ASSERT_NEXT(a_busy, i_valid && !o_stall, o_stall)

    // A stalled result beat stays offered and unchanged.
    `CMSC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_beat))

endmodule

bind clock_mult_shift_calc cmsc_check #(.MAX_SHIFT(MAX_SHIFT)) u_cmsc_check (.*);
